### design/bta_pkg.sv
// Shared types, constants and codes for the binary tree array traversal block.
// No dependencies; imported by every module of the block.
package bta_pkg;

	localparam int NODE_SLOTS  = 64;
	localparam int IDX_BITS    = $clog2(NODE_SLOTS);
	localparam int CHILD_BITS  = IDX_BITS + 1;
	localparam int VALUE_BITS  = 16;
	localparam int MAX_VISITS  = 63;
	localparam int COUNT_BITS  = 6;
	// one stack entry per tree level
	localparam int STACK_SLOTS = IDX_BITS;
	localparam int TOP_BITS    = $clog2(STACK_SLOTS);
	localparam int DEPTH_BITS  = $clog2(STACK_SLOTS + 1);

	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	// action codes
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_WALK  = 2'd2;

	// traversal_order codes
	localparam logic [1:0] ORDER_PRE  = 2'd0;
	localparam logic [1:0] ORDER_IN   = 2'd1;
	localparam logic [1:0] ORDER_POST = 2'd2;

	// per-entry walk phase: before left child, between children, after right child
	localparam logic [1:0] PH_PRE  = 2'd0;
	localparam logic [1:0] PH_MID  = 2'd1;
	localparam logic [1:0] PH_POST = 2'd2;

	// register indexes
	localparam logic REG_ORDER = 1'b0;

	typedef struct packed {
		logic [1:0]                   action;
		logic [IDX_BITS-1:0]          node_index;
		logic signed [VALUE_BITS-1:0] node_value;
		logic                         node_valid;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] visit_value;
		logic [IDX_BITS-1:0]          visit_index;
		logic                         last;
		logic                         empty_walk;
	} out_item_t;

	typedef struct packed {
		logic clear_all;
		logic write_node;
		logic start_walk;
		logic empty_walk;
		logic do_step;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic root_ok;
		logic emit_hit;
		logic pop_last;
		logic cap_hit;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

endpackage

### design/bta_datapath.sv
// Datapath: node value memory, present bits, walk stack, result holding stage.
// Depends on bta_pkg; driven by bta_ctrl.
module bta_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  bta_pkg::in_item_t  in_data,
	input  logic [1:0]         order,
	input  bta_pkg::dp_cmd_t   cmd,
	output bta_pkg::dp_status_t status,
	output logic               out_valid,
	input  logic               out_ready,
	output bta_pkg::out_item_t out_data
);
	import bta_pkg::*;

	logic [VALUE_BITS-1:0] mem [NODE_SLOTS];
	logic [VALUE_BITS-1:0] rdata_q;
	logic [NODE_SLOTS-1:0] present_q;

	logic [IDX_BITS-1:0]   stk_idx_q [STACK_SLOTS];
	logic [1:0]            stk_ph_q  [STACK_SLOTS];
	logic [VALUE_BITS-1:0] stk_val_q [STACK_SLOTS];
	logic [DEPTH_BITS-1:0] depth_q;
	logic                  fresh_q;
	logic [COUNT_BITS-1:0] count_q;

	out_item_t pend_q;
	logic      pend_valid_q;
	out_item_t out_q;
	logic      out_valid_q;

	logic [DEPTH_BITS-1:0] top_full;
	logic [TOP_BITS-1:0]   top;
	logic [TOP_BITS-1:0]   push_slot;
	logic [IDX_BITS-1:0]   cur_idx;
	logic [1:0]            cur_ph;
	logic [VALUE_BITS-1:0] cur_val;
	logic [CHILD_BITS-1:0] child;
	logic                  child_ok;
	logic [1:0]            emit_phase;
	logic                  emit_hit;
	logic                  push;
	logic                  rd_en;
	logic [IDX_BITS-1:0]   rd_addr;
	logic                  out_load;

	always_comb begin
		unique case (order)
			ORDER_IN:   emit_phase = PH_MID;
			ORDER_POST: emit_phase = PH_POST;
			default:    emit_phase = PH_PRE;
		endcase
	end

	assign top_full  = depth_q - DEPTH_BITS'(1);
	assign top       = top_full[TOP_BITS-1:0];
	assign push_slot = depth_q[TOP_BITS-1:0];
	assign cur_idx   = stk_idx_q[top];
	assign cur_ph    = stk_ph_q[top];
	// a node just pushed has its value only in the read register until its first step
	assign cur_val   = fresh_q ? rdata_q : stk_val_q[top];
	assign child     = {cur_idx, cur_ph[0]};
	assign child_ok  = (cur_ph != PH_POST) && (child < CHILD_BITS'(NODE_SLOTS))
		&& present_q[child[IDX_BITS-1:0]];
	assign emit_hit  = (cur_ph == emit_phase);
	assign push      = cmd.do_step && child_ok;

	assign rd_en   = cmd.start_walk || push;
	assign rd_addr = cmd.start_walk ? in_data.node_index : child[IDX_BITS-1:0];

	assign out_load = (cmd.do_step && emit_hit && pend_valid_q) || cmd.flush;

	assign status.root_ok    = (in_data.node_index != '0) && present_q[in_data.node_index];
	assign status.emit_hit   = emit_hit;
	assign status.pop_last   = (cur_ph == PH_POST) && (depth_q == DEPTH_BITS'(1));
	assign status.cap_hit    = (count_q == COUNT_BITS'(MAX_VISITS - 1));
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// node value memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write_node && in_data.node_valid) begin
			mem[in_data.node_index] <= in_data.node_value;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (cmd.clear_all) begin
			present_q <= '0;
		end else if (cmd.write_node) begin
			present_q[in_data.node_index] <= in_data.node_valid;
		end
	end

	// stack payload
	always_ff @(posedge clk) begin
		if (cmd.start_walk) begin
			stk_idx_q[0] <= in_data.node_index;
			stk_ph_q[0]  <= PH_PRE;
		end else if (cmd.do_step) begin
			if (fresh_q) begin
				stk_val_q[top] <= rdata_q;
			end
			if (cur_ph != PH_POST) begin
				stk_ph_q[top] <= cur_ph + 2'd1;
			end
			if (push) begin
				stk_idx_q[push_slot] <= child[IDX_BITS-1:0];
				stk_ph_q[push_slot]  <= PH_PRE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			fresh_q <= 1'b0;
			count_q <= '0;
		end else if (cmd.start_walk) begin
			depth_q <= DEPTH_BITS'(1);
			fresh_q <= 1'b1;
			count_q <= '0;
		end else if (cmd.do_step) begin
			fresh_q <= push;
			if (emit_hit) begin
				count_q <= count_q + COUNT_BITS'(1);
			end
			if (cur_ph == PH_POST) begin
				depth_q <= depth_q - DEPTH_BITS'(1);
			end else if (push) begin
				depth_q <= depth_q + DEPTH_BITS'(1);
			end
		end else if (cmd.flush) begin
			depth_q <= '0;
			fresh_q <= 1'b0;
		end
	end

	// holding stage: a visit waits here until the next one proves it was not the last
	always_ff @(posedge clk) begin
		if (cmd.empty_walk) begin
			pend_q <= '{visit_value: '0, visit_index: '0, last: 1'b1, empty_walk: 1'b1};
		end else if (cmd.do_step && emit_hit) begin
			pend_q <= '{visit_value: cur_val, visit_index: cur_idx, last: 1'b0,
				empty_walk: 1'b0};
		end
		if (out_load) begin
			// a flush marks the held visit as the final one of its walk
			out_q <= '{visit_value: pend_q.visit_value, visit_index: pend_q.visit_index,
				last: pend_q.last || cmd.flush, empty_walk: pend_q.empty_walk};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.empty_walk || (cmd.do_step && emit_hit)) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/bta_ctrl.sv
// Controller state machine: decodes actions, sequences walk steps and final flush.
// Depends on bta_pkg; commands bta_datapath.
module bta_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  bta_pkg::dp_status_t status,
	output bta_pkg::dp_cmd_t    cmd
);
	import bta_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_STEP  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;
	logic       stall;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	// a new visit must push the held one out, which needs the output free
	assign stall    = status.emit_hit && status.pend_valid && !status.out_free;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_CLEAR: cmd.clear_all = 1'b1;
						ACT_WRITE: cmd.write_node = 1'b1;
						ACT_WALK: begin
							if (status.root_ok) begin
								cmd.start_walk = 1'b1;
								state_d        = ST_STEP;
							end else begin
								cmd.empty_walk = 1'b1;
								state_d        = ST_FLUSH;
							end
						end
						default: ;
					endcase
				end
			end
			ST_STEP: begin
				if (!stall) begin
					cmd.do_step = 1'b1;
					if (status.pop_last || (status.emit_hit && status.cap_hit)) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (status.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/binary_tree_array_traversal.sv
// Top level of the binary tree array traversal block: APB register, controller, datapath.
// Depends on bta_pkg, bta_ctrl and bta_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one transaction per action:
//   clear all nodes, write one node (value plus present flag), or walk from a root.
//   Output channel (out_valid/out_ready/out_data) returns one transaction per
//   visited node, in the order set by the traversal_order register (APB, address 0).
//   The final transaction of a walk has last set; an empty walk (root 0 or root
//   not present) returns a single transaction with last and empty_walk set.
// Sequencing:
//   Clear and write are done in the cycle they are accepted and leave the block
//   ready for the next transaction. A walk makes one stack step per cycle
//   while the output does not stall it, three steps per visited node. Results
//   trail the walk by one visit, held until the next visit shows they are not
//   the last one. An empty walk goes straight to the final flush.
// Reset:
//   arst_n clears every present bit, the walk stack depth and the output stage; node
//   values stay undefined until written. traversal_order resets to preorder.
// Stall:
//   While out_ready is low the walk runs on until the holding stage and output
//   register are both full, then pauses; nothing is dropped.
module binary_tree_array_traversal (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bta_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bta_pkg::out_item_t              out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bta_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [bta_pkg::DATA_BITS-1:0]   pwdata,
	output logic [bta_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready
);
	import bta_pkg::*;

	logic       order_wr;
	logic [1:0] order_q;
	dp_cmd_t    cmd;
	dp_status_t status;

	// register index is the word address; the low two byte-address bits are ignored
	assign pready   = 1'b1;
	assign order_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ORDER);
	assign prdata   = (paddr[2] == REG_ORDER) ? {{(DATA_BITS-2){1'b0}}, order_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_PRE;
		end else if (order_wr) begin
			order_q <= pwdata[1:0];
		end
	end

	bta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (in_data.action),
		.status   (status),
		.cmd      (cmd)
	);

	bta_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.order     (order_q),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
